[hw/rtl/floppy_head_seek_sequencer_defines.svh]
// Assertion shorthands for the head seek sequencer, clocked on i_clk with
// the synchronous active-low reset masking every check.
`ifndef FLOPPY_HEAD_SEEK_SEQUENCER_DEFINES_SVH
`define FLOPPY_HEAD_SEEK_SEQUENCER_DEFINES_SVH

// Same-cycle implication.
`define FHS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fhs: same-cycle check failed");

// Next-cycle implication.
`define FHS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fhs: next-cycle check failed");

`endif

[hw/rtl/fhs_pkg.sv]
package fhs_pkg;

    // Fixed field widths
    localparam int CylFieldBits = 7;
    localparam int TickBits     = 16;
    localparam int LimitBits    = 7;

    // Parameter defaults
    localparam int DefCylBits  = 7;
    localparam int DefWaitBits = 16;

    // Register reset values
    localparam logic [TickBits-1:0]  RstStepInterval = 16'd30;
    localparam logic [TickBits-1:0]  RstReverseWait  = 16'd180;
    localparam logic [TickBits-1:0]  RstSideWait     = 16'd20;
    localparam logic [TickBits-1:0]  RstSeekSettle   = 16'd150;
    localparam logic [TickBits-1:0]  RstHeadSettle   = 16'd1;
    localparam logic [LimitBits-1:0] RstRecalLimit   = 7'd80;
    localparam logic [LimitBits-1:0] RstCylCount     = 7'd80;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SEEK   = 2'd1,
        OP_RECAL  = 2'd2,
        OP_BOUNCE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TIMEOUT = 3'd1,
        ST_BUSY    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_RANGE   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CFG_STEP_INTERVAL = 3'd0,
        CFG_REVERSE_WAIT  = 3'd1,
        CFG_SIDE_WAIT     = 3'd2,
        CFG_SEEK_SETTLE   = 3'd3,
        CFG_HEAD_SETTLE   = 3'd4,
        CFG_RECAL_LIMIT   = 3'd5,
        CFG_CYL_COUNT     = 3'd6
    } t_cfg_idx;

    // Outcome flags of a seek plan
    typedef struct packed {
        logic range_err;
        logic inward;
        logic moving;
    } t_plan;

endpackage

[hw/rtl/floppy_head_seek_sequencer.sv]
// Channel  | Handshake                  | Payload
// ---------+----------------------------+---------------------------------------------
// in       | i_in_valid / o_in_ready    | i_operation, i_target_cylinder,
//          |                            | i_target_head, i_at_track0
// out      | o_out_valid / i_out_ready  | o_step_pulse, o_step_inward, o_head_select,
//          |                            | o_busy_res, o_done_res, o_status,
//          |                            | o_current_cylinder, o_position_known, o_did_step
// cfg      | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One item per clock: the sequencer state and the result register update on
// the edge that accepts the item, so the result appears in the cycle after.
// The single result register sets the rate: o_in_ready falls only while a
// result waits and i_out_ready is low, and a taken result frees it at once.
// Reset (synchronous, i_rst_n low) returns to idle, position unknown, and
// loads the default timings; no clearing pass is needed.
`include "floppy_head_seek_sequencer_defines.svh"

module floppy_head_seek_sequencer
    import fhs_pkg::*;
#(
    parameter int CYL_BITS  = DefCylBits,
    parameter int WAIT_BITS = DefWaitBits
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_index,
    input  logic [TickBits-1:0]     i_cfg_data,

    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_operation,
    input  logic [CylFieldBits-1:0] i_target_cylinder,
    input  logic                    i_target_head,
    input  logic                    i_at_track0,

    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_step_pulse,
    output logic                    o_step_inward,
    output logic                    o_head_select,
    output logic                    o_busy_res,
    output logic                    o_done_res,
    output logic [2:0]              o_status,
    output logic [CylFieldBits-1:0] o_current_cylinder,
    output logic                    o_position_known,
    output logic                    o_did_step
);

    // Compare width: room for any cylinder value plus one
    localparam int CW = ((CYL_BITS > CylFieldBits) ? CYL_BITS : CylFieldBits) + 1;
    // Saturation width for wait loads
    localparam int WW = (WAIT_BITS > TickBits) ? WAIT_BITS : TickBits;
    localparam logic [WW-1:0] WaitMax = WW'((64'd1 << WAIT_BITS) - 64'd1);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRE     = 3'd1,
        PH_STEP    = 3'd2,
        PH_SETTLE  = 3'd3,
        PH_RWAIT   = 3'd4,
        PH_RSETTLE = 3'd5
    } t_phase;

    // Clamp a tick count to the wait counter
    function automatic logic [WAIT_BITS-1:0] sat_wait(input logic [TickBits-1:0] v);
        logic [WW-1:0] x;
        x = WW'(v);
        return (x > WaitMax) ? WaitMax[WAIT_BITS-1:0] : x[WAIT_BITS-1:0];
    endfunction

    // Configuration registers
    logic [TickBits-1:0]  r_cfg_step, r_cfg_reverse, r_cfg_side, r_cfg_seek_settle;
    logic [TickBits-1:0]  r_cfg_head_settle;
    logic [LimitBits-1:0] r_cfg_limit, r_cfg_cyls;

    // Sequencer state
    t_phase                r_phase, n_phase;
    logic [CYL_BITS-1:0]   r_cyl, n_cyl;
    logic                  r_known, n_known;
    logic                  r_head, n_head;
    logic                  r_last_in, n_last_in;
    logic                  r_bounce_in, n_bounce_in;
    logic [CYL_BITS-1:0]   r_steps, n_steps;
    logic [WAIT_BITS-1:0]  r_wait, n_wait;
    logic [LimitBits-1:0]  r_recal, n_recal;
    logic                  r_pend, n_pend;

    // Result register
    logic                    r_out_valid;
    logic                    r_step_pulse, r_step_inward, r_head_select, r_busy, r_done;
    logic [2:0]              r_status;
    logic [CylFieldBits-1:0] r_cur_cyl;
    logic                    r_pos_known, r_did_step;

    logic                  in_accept;
    logic                  busy;
    t_op                   op;
    t_status               res_status;
    logic                  res_pulse, res_dir, res_done;
    logic [TickBits-1:0]   settle;
    logic [WAIT_BITS-1:0]  wait_dec;
    logic [CW-1:0]         cur_w, cc_w, b_c, seek_tgt;
    logic                  b_neg, b_flag;
    logic                  seek_head, seek_bad;
    t_plan                 plan;
    logic [CYL_BITS-1:0]   plan_steps;
    logic [TickBits-1:0]   plan_pre;
    logic [CW-1:0]         n_cyl_w;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign busy       = (r_phase != PH_IDLE);
    assign op         = t_op'(i_operation);
    assign cur_w      = CW'(r_cyl);
    assign cc_w       = CW'(r_cfg_cyls);

    // Bounce target: neighbour cylinder, turning at either end
    always_comb begin
        b_flag = r_bounce_in;
        if (r_bounce_in) begin
            b_c   = cur_w + CW'(1);
            b_neg = 1'b0;
        end else if (r_cyl == '0) begin
            b_c   = '0;
            b_neg = 1'b1;
        end else begin
            b_c   = cur_w - CW'(1);
            b_neg = 1'b0;
        end
        if (!b_neg && (cc_w != '0) && (b_c > (cc_w - CW'(1)))) begin
            b_neg  = (r_cyl == '0);
            b_c    = b_neg ? '0 : (cur_w - CW'(1));
            b_flag = 1'b0;
        end else if (b_neg) begin
            b_c    = CW'(1);
            b_flag = 1'b1;
        end
    end

    assign seek_tgt  = (op == OP_SEEK) ? CW'(i_target_cylinder) : b_c;
    assign seek_head = (op == OP_SEEK) ? i_target_head : r_head;

    fhs_seek_plan #(
        .CYL_BITS (CYL_BITS)
    ) u_plan (
        .i_target       (seek_tgt),
        .i_cur          (r_cyl),
        .i_last_inward  (r_last_in),
        .i_cyl_count    (r_cfg_cyls),
        .i_reverse_wait (r_cfg_reverse),
        .i_side_wait    (r_cfg_side),
        .o_plan         (plan),
        .o_steps        (plan_steps),
        .o_pre          (plan_pre)
    );

    assign seek_bad = plan.range_err ||
                      ((op == OP_BOUNCE) && (b_neg || (r_cfg_cyls == '0)));
    assign wait_dec = (r_wait != '0) ? (r_wait - WAIT_BITS'(1)) : r_wait;

    // Next state and result for the offered item
    always_comb begin
        n_phase     = r_phase;
        n_cyl       = r_cyl;
        n_known     = r_known;
        n_head      = r_head;
        n_last_in   = r_last_in;
        n_bounce_in = r_bounce_in;
        n_steps     = r_steps;
        n_wait      = r_wait;
        n_recal     = r_recal;
        n_pend      = r_pend;
        res_pulse   = 1'b0;
        res_dir     = 1'b0;
        res_done    = 1'b0;
        res_status  = ST_OK;
        settle      = '0;

        if (op != OP_TICK) begin
            res_done = 1'b1;
            if (busy) begin
                res_status = ST_BUSY;
            end else if (op == OP_RECAL) begin
                // Forget the position and start the outward walk
                res_done = 1'b0;
                n_known  = 1'b0;
                n_recal  = '0;
                n_pend   = 1'b0;
                n_steps  = '0;
                n_wait   = sat_wait(r_cfg_reverse);
                n_phase  = PH_RWAIT;
            end else if (!r_known) begin
                res_status = ST_UNKNOWN;
            end else if (seek_bad) begin
                res_status = ST_RANGE;
            end else begin
                res_done = 1'b0;
                if (plan.moving) begin
                    n_last_in = plan.inward;
                end
                n_steps = plan_steps;
                n_pend  = (r_head != seek_head);
                n_wait  = sat_wait(plan_pre);
                n_phase = PH_PRE;
                if (op == OP_BOUNCE) begin
                    n_bounce_in = ~b_flag;
                end
            end
        end else if (busy) begin
            n_wait = wait_dec;
            if (wait_dec == '0) begin
                case (r_phase)
                    PH_PRE, PH_STEP: begin
                        if (r_steps != '0) begin
                            res_pulse = 1'b1;
                            res_dir   = r_last_in;
                            n_cyl     = r_last_in ? (r_cyl + CYL_BITS'(1))
                                                  : (r_cyl - CYL_BITS'(1));
                            n_steps   = r_steps - CYL_BITS'(1);
                            n_wait    = sat_wait(r_cfg_step);
                            n_phase   = PH_STEP;
                        end else begin
                            // Settle for the longer of seek settle (after steps) and head settle (after a head change)
                            if (r_phase == PH_STEP) begin
                                settle = r_cfg_seek_settle;
                            end
                            if (r_pend && (r_cfg_head_settle > settle)) begin
                                settle = r_cfg_head_settle;
                            end
                            n_head  = r_head ^ r_pend;
                            n_pend  = 1'b0;
                            n_wait  = sat_wait(settle);
                            n_phase = PH_SETTLE;
                        end
                    end
                    PH_SETTLE: begin
                        n_phase  = PH_IDLE;
                        res_done = 1'b1;
                    end
                    PH_RWAIT: begin
                        if (i_at_track0) begin
                            n_head  = 1'b0;
                            n_wait  = sat_wait(r_cfg_seek_settle);
                            n_phase = PH_RSETTLE;
                        end else begin
                            res_pulse = 1'b1;
                            if (r_recal >= r_cfg_limit) begin
                                // Step limit passed: give up, position unknown
                                n_phase    = PH_IDLE;
                                res_done   = 1'b1;
                                res_status = ST_TIMEOUT;
                            end else begin
                                n_recal = r_recal + LimitBits'(1);
                                n_wait  = sat_wait(r_cfg_step);
                            end
                        end
                    end
                    PH_RSETTLE: begin
                        n_cyl     = '0;
                        n_head    = 1'b0;
                        n_last_in = 1'b0;
                        n_known   = 1'b1;
                        n_phase   = PH_IDLE;
                        res_done  = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    assign n_cyl_w = CW'(n_cyl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_step        <= RstStepInterval;
            r_cfg_reverse     <= RstReverseWait;
            r_cfg_side        <= RstSideWait;
            r_cfg_seek_settle <= RstSeekSettle;
            r_cfg_head_settle <= RstHeadSettle;
            r_cfg_limit       <= RstRecalLimit;
            r_cfg_cyls        <= RstCylCount;
            r_phase           <= PH_IDLE;
            r_cyl             <= '0;
            r_known           <= 1'b0;
            r_head            <= 1'b0;
            r_last_in         <= 1'b0;
            r_bounce_in       <= 1'b0;
            r_steps           <= '0;
            r_wait            <= '0;
            r_recal           <= '0;
            r_pend            <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_STEP_INTERVAL: r_cfg_step        <= i_cfg_data;
                    CFG_REVERSE_WAIT:  r_cfg_reverse     <= i_cfg_data;
                    CFG_SIDE_WAIT:     r_cfg_side        <= i_cfg_data;
                    CFG_SEEK_SETTLE:   r_cfg_seek_settle <= i_cfg_data;
                    CFG_HEAD_SETTLE:   r_cfg_head_settle <= i_cfg_data;
                    CFG_RECAL_LIMIT:   r_cfg_limit       <= i_cfg_data[LimitBits-1:0];
                    CFG_CYL_COUNT:     r_cfg_cyls        <= i_cfg_data[LimitBits-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_phase     <= n_phase;
                r_cyl       <= n_cyl;
                r_known     <= n_known;
                r_head      <= n_head;
                r_last_in   <= n_last_in;
                r_bounce_in <= n_bounce_in;
                r_steps     <= n_steps;
                r_wait      <= n_wait;
                r_recal     <= n_recal;
                r_pend      <= n_pend;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_step_pulse  <= res_pulse;
            r_step_inward <= res_dir;
            r_head_select <= n_head;
            r_busy        <= (n_phase != PH_IDLE);
            r_done        <= res_done;
            r_status      <= res_status;
            r_cur_cyl     <= n_cyl_w[CylFieldBits-1:0];
            r_pos_known   <= n_known;
            r_did_step    <= n_known && (n_recal != '0);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_step_pulse       = r_step_pulse;
    assign o_step_inward      = r_step_inward;
    assign o_head_select      = r_head_select;
    assign o_busy_res         = r_busy;
    assign o_done_res         = r_done;
    assign o_status           = r_status;
    assign o_current_cylinder = r_cur_cyl;
    assign o_position_known   = r_pos_known;
    assign o_did_step         = r_did_step;

    `FHS_ASSERT_NEXT(a_accept_gives_result, in_accept, r_out_valid)
    `FHS_ASSERT_NOW(a_status_only_when_done, r_out_valid && (r_status != ST_OK), r_done)
    `FHS_ASSERT_NOW(a_dir_only_with_pulse, r_out_valid && !r_step_pulse, !r_step_inward)
    `FHS_ASSERT_NOW(a_did_step_needs_known, r_out_valid && r_did_step, r_pos_known)
    `FHS_ASSERT_NOW(a_timeout_idle, r_out_valid && r_status == ST_TIMEOUT, !(r_pos_known || r_busy))

endmodule

[hw/rtl/fhs_seek_plan.sv]
module fhs_seek_plan
    import fhs_pkg::*;
#(
    parameter int CYL_BITS = DefCylBits
) (
    input  logic [((CYL_BITS > CylFieldBits) ? CYL_BITS : CylFieldBits):0] i_target,
    input  logic [CYL_BITS-1:0]  i_cur,
    input  logic                 i_last_inward,
    input  logic [LimitBits-1:0] i_cyl_count,
    input  logic [TickBits-1:0]  i_reverse_wait,
    input  logic [TickBits-1:0]  i_side_wait,
    output t_plan                o_plan,
    output logic [CYL_BITS-1:0]  o_steps,
    output logic [TickBits-1:0]  o_pre
);

    localparam int CW = ((CYL_BITS > CylFieldBits) ? CYL_BITS : CylFieldBits) + 1;
    localparam logic [CW-1:0] CylMask = CW'((64'd1 << CYL_BITS) - 64'd1);

    logic [CW-1:0] cur_w;
    logic [CW-1:0] diff;
    logic          inward;
    logic          moving;

    assign cur_w  = CW'(i_cur);
    assign inward = (i_target >= cur_w);
    assign diff   = inward ? (i_target - cur_w) : (cur_w - i_target);
    assign moving = (diff != '0);

    assign o_plan.range_err = (i_target > CylMask) || (i_target >= CW'(i_cyl_count));
    assign o_plan.inward    = inward;
    assign o_plan.moving    = moving;
    assign o_steps          = diff[CYL_BITS-1:0];

    // Stretch the pre-wait when the head must reverse
    assign o_pre = (moving && (inward != i_last_inward) && (i_reverse_wait > i_side_wait))
                   ? i_reverse_wait : i_side_wait;

endmodule
